// ===== src/zbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// zbpf_pkg
// Shared types and constants of the z-buffer polygon fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package zbpf_pkg;

    localparam int MAX_VERTICES  = 8;
    localparam int SCREEN_WIDTH  = 512;
    localparam int SCREEN_HEIGHT = 512;

    localparam int VIDX_W    = $clog2(MAX_VERTICES);
    localparam int VCNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int XCOL_W    = $clog2(SCREEN_WIDTH);
    localparam int YROW_W    = $clog2(SCREEN_HEIGHT);
    localparam int PIX_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PIX_W     = $clog2(PIX_DEPTH);

    localparam int COORD_W = 12;
    localparam int VZ_W    = 11;
    localparam int DEPTH_W = 24;
    localparam int COLOR_W = 24;
    localparam int VTX_W   = 2 * COORD_W + VZ_W;

    // Plane and datapath widths.
    localparam int PLANE_W = 26;
    localparam int PD_W    = 40;
    localparam int MULA_W  = 27;
    localparam int MULB_W  = 14;
    localparam int PROD_W  = MULA_W + MULB_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int SUM_W   = ACC_W + 1;
    localparam int NUM_W   = SUM_W + 8;
    localparam int STEP_W  = $clog2(NUM_W);

    localparam logic CFG_CLEAR_DEPTH = 1'b0;
    localparam logic CFG_CLEAR_COLOR = 1'b1;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_TEST   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [VZ_W-1:0]     z;
        logic                       last;
        logic [COLOR_W-1:0]         color;
        logic                       on_screen;
        logic [PIX_W-1:0]           pix;
    } item_t;

endpackage

`default_nettype wire

// ===== src/zbpf_front.sv =====
// ----------------------------------------------------------------------------
// zbpf_front
// Accepts input beats, works out screen membership and the pixel address,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module zbpf_front
    import zbpf_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_kind,
    input  wire logic signed [COORD_W-1:0] s_coord_x,
    input  wire logic signed [COORD_W-1:0] s_coord_y,
    input  wire logic signed [VZ_W-1:0]    s_vertex_depth,
    input  wire logic                      s_last_vertex,
    input  wire logic [7:0]                s_color_red,
    input  wire logic [7:0]                s_color_green,
    input  wire logic [7:0]                s_color_blue,
    output logic                           q_valid,
    input  wire logic                      q_ready,
    output item_t                          q_item
);

    item_t       fifo_mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    item_t       in_item;
    logic        on_x, on_y, push, pop;
    logic [XCOL_W-1:0] xcol;
    logic [YROW_W-1:0] yrow;

    always_comb begin
        on_x = !s_coord_x[COORD_W-1] &&
               ((COORD_W+1)'(s_coord_x) < (COORD_W+1)'(SCREEN_WIDTH));
        on_y = !s_coord_y[COORD_W-1] &&
               ((COORD_W+1)'(s_coord_y) < (COORD_W+1)'(SCREEN_HEIGHT));
        xcol = s_coord_x[XCOL_W-1:0];
        yrow = s_coord_y[YROW_W-1:0];
        in_item.kind      = kind_t'(s_kind);
        in_item.x         = s_coord_x;
        in_item.y         = s_coord_y;
        in_item.z         = s_vertex_depth;
        in_item.last      = s_last_vertex;
        in_item.color     = {s_color_red, s_color_green, s_color_blue};
        in_item.on_screen = on_x && on_y;
        in_item.pix       = PIX_W'(PIX_W'(yrow) * PIX_W'(SCREEN_WIDTH) + PIX_W'(xcol));
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== src/zbpf_back.sv =====
// ----------------------------------------------------------------------------
// zbpf_back
// Sequencer that carries out one item at a time: vertex loads and plane
// setup, the edge crossing walk, the depth division and the pixel stores.
// ----------------------------------------------------------------------------
`default_nettype none

module zbpf_back
    import zbpf_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic signed [DEPTH_W-1:0] clear_depth,
    input  wire logic [COLOR_W-1:0]        clear_color,
    input  wire logic                      q_valid,
    output logic                           q_ready,
    input  item_t                          q_item,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_inside_res,
    output logic                           m_written,
    output logic                           m_degenerate,
    output logic signed [DEPTH_W-1:0]      m_pixel_depth,
    output logic [7:0]                     m_pixel_red,
    output logic [7:0]                     m_pixel_green,
    output logic [7:0]                     m_pixel_blue
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_VTX    = 8'b0000_0010,
        ST_PLANE  = 8'b0000_0100,
        ST_FETCH  = 8'b0000_1000,
        ST_EDGE   = 8'b0001_0000,
        ST_DEPTH  = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_UPDATE = 8'b1000_0000
    } state_t;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    item_t  item_reg, item_next;

    logic [VCNT_W-1:0] vcount_reg, vcount_next;
    logic              complete_reg, complete_next;
    logic signed [PLANE_W-1:0] pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic signed [PD_W-1:0]    pd_reg, pd_next;
    logic [COLOR_W-1:0]        pcolor_reg, pcolor_next;

    logic signed [COORD_W:0] dx1_reg, dx1_next, dy1_reg, dy1_next;
    logic signed [COORD_W:0] dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic signed [VZ_W:0]    dz1_reg, dz1_next, dz2_reg, dz2_next;

    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_reg, lhs_reg, lhs_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic [VCNT_W-1:0] edge_reg, edge_next;
    logic              hits_reg, hits_next, cross_reg, cross_next;
    logic              dypos_reg, dypos_next;

    logic [NUM_W-1:0]   dvd_reg, dvd_next;
    logic [PLANE_W-1:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic               qneg_reg, qneg_next, depth_ok_reg, depth_ok_next;

    logic                      res_inside_reg, res_inside_next;
    logic                      res_written_reg, res_written_next;
    logic [DEPTH_W-1:0]        res_depth_reg, res_depth_next;
    logic [COLOR_W-1:0]        res_color_reg, res_color_next;

    logic                      m_valid_reg, m_inside_reg, m_written_reg, m_degen_reg;
    logic [DEPTH_W-1:0]        m_depth_reg;
    logic [COLOR_W-1:0]        m_color_reg;

    // Vertex store: one write port, two registered read ports.
    logic [VTX_W-1:0]  vtx_mem [MAX_VERTICES];
    logic [VTX_W-1:0]  rd0_reg, rd1_reg, vtx_wd;
    logic [VIDX_W-1:0] ra0, ra1, vtx_wa;
    logic              vtx_we;

    // Pixel store: depth in the upper half, color in the lower half.
    logic [DEPTH_W+COLOR_W-1:0] pix_mem [PIX_DEPTH];
    logic [DEPTH_W+COLOR_W-1:0] pix_rd_reg, pix_wd;
    logic                       pix_we;

    logic signed [COORD_W-1:0] v0x, v0y, v1x, v1y;
    logic signed [VZ_W-1:0]    v0z, v1z;
    logic signed [COORD_W:0]   dyv, xdiff, bxa, yay;
    logic signed [SUM_W-1:0]   sum_w, sum_mag;
    logic [VCNT_W-1:0]         eff_cnt, edge_inc;
    logic [PLANE_W:0]          trial;
    logic                      degen, out_free, inside_w;
    logic signed [DEPTH_W-1:0] zsat, stored_depth;

    assign v0x = $signed(rd0_reg[VTX_W-1 -: COORD_W]);
    assign v0y = $signed(rd0_reg[VZ_W +: COORD_W]);
    assign v0z = $signed(rd0_reg[VZ_W-1:0]);
    assign v1x = $signed(rd1_reg[VTX_W-1 -: COORD_W]);
    assign v1y = $signed(rd1_reg[VZ_W +: COORD_W]);
    assign v1z = $signed(rd1_reg[VZ_W-1:0]);

    assign degen    = !complete_reg || (vcount_reg < VCNT_W'(3)) || (pc_reg == '0);
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_IDLE) && !done_reg;
    assign edge_inc = edge_reg + VCNT_W'(1);
    assign stored_depth = $signed(pix_rd_reg[DEPTH_W+COLOR_W-1 -: DEPTH_W]);

    always_comb begin
        if (state_reg == ST_PLANE) begin
            ra0 = '0;
            ra1 = (step_reg == '0) ? VIDX_W'(1) : VIDX_W'(2);
        end else begin
            ra0 = edge_reg[VIDX_W-1:0];
            ra1 = (edge_inc == vcount_reg) ? '0 : edge_inc[VIDX_W-1:0];
        end
    end

    // Saturated quotient with the sign applied.
    always_comb begin
        if (qneg_reg) begin
            zsat = (dvd_reg > NUM_W'(DEPTH_MIN)) ? $signed(DEPTH_MIN)
                                                 : $signed(DEPTH_W'(-dvd_reg));
        end else begin
            zsat = (dvd_reg > NUM_W'(DEPTH_MAX)) ? $signed(DEPTH_MAX)
                                                 : $signed(dvd_reg[DEPTH_W-1:0]);
        end
    end

    always_comb begin
        state_next       = state_reg;
        done_next        = done_reg;
        step_next        = step_reg;
        item_next        = item_reg;
        vcount_next      = vcount_reg;
        complete_next    = complete_reg;
        pa_next          = pa_reg;
        pb_next          = pb_reg;
        pc_next          = pc_reg;
        pd_next          = pd_reg;
        pcolor_next      = pcolor_reg;
        dx1_next         = dx1_reg;
        dy1_next         = dy1_reg;
        dz1_next         = dz1_reg;
        dx2_next         = dx2_reg;
        dy2_next         = dy2_reg;
        dz2_next         = dz2_reg;
        acc_next         = acc_reg;
        lhs_next         = lhs_reg;
        edge_next        = edge_reg;
        hits_next        = hits_reg;
        cross_next       = cross_reg;
        dypos_next       = dypos_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        qneg_next        = qneg_reg;
        depth_ok_next    = depth_ok_reg;
        res_inside_next  = res_inside_reg;
        res_written_next = res_written_reg;
        res_depth_next   = res_depth_reg;
        res_color_next   = res_color_reg;
        mul_a            = '0;
        mul_b            = '0;
        vtx_we           = 1'b0;
        vtx_wa           = '0;
        vtx_wd           = {item_reg.x, item_reg.y, item_reg.z};
        pix_we           = 1'b0;
        pix_wd           = {clear_depth, clear_color};
        eff_cnt          = complete_reg ? '0 : vcount_reg;
        dyv              = (COORD_W+1)'(v1y) - (COORD_W+1)'(v0y);
        xdiff            = (COORD_W+1)'(item_reg.x) - (COORD_W+1)'(v0x);
        bxa              = (COORD_W+1)'(v1x) - (COORD_W+1)'(v0x);
        yay              = (COORD_W+1)'(item_reg.y) - (COORD_W+1)'(v0y);
        sum_w            = SUM_W'(acc_reg) + SUM_W'(prod_reg) + SUM_W'(pd_reg);
        sum_mag          = sum_w[SUM_W-1] ? -sum_w : sum_w;
        trial            = {rem_reg, dvd_reg[NUM_W-1]} - {1'b0, dvs_reg};
        inside_w         = hits_reg && complete_reg && (item_reg.kind == KIND_TEST);

        unique case (state_reg)
            ST_IDLE: begin
                if (done_reg) begin
                    // A finished result waits here for the output register.
                    if (out_free) begin
                        done_next = 1'b0;
                    end
                end else if (q_valid) begin
                    item_next     = q_item;
                    step_next     = '0;
                    hits_next     = 1'b0;
                    edge_next     = '0;
                    depth_ok_next = 1'b0;
                    state_next    = (q_item.kind == KIND_VERTEX) ? ST_VTX : ST_FETCH;
                end
            end
            ST_VTX: begin
                res_inside_next  = 1'b0;
                res_written_next = 1'b0;
                res_depth_next   = '0;
                res_color_next   = '0;
                vcount_next      = eff_cnt;
                if (eff_cnt < VCNT_W'(MAX_VERTICES)) begin
                    vtx_we      = 1'b1;
                    vtx_wa      = eff_cnt[VIDX_W-1:0];
                    vcount_next = eff_cnt + VCNT_W'(1);
                end
                complete_next = item_reg.last;
                if (item_reg.last) begin
                    pcolor_next = item_reg.color;
                    if (vcount_next < VCNT_W'(3)) begin
                        pa_next    = '0;
                        pb_next    = '0;
                        pc_next    = '0;
                        pd_next    = '0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        step_next  = '0;
                        state_next = ST_PLANE;
                    end
                end else begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PLANE: begin
                // One multiply per step; each product is used a step later.
                step_next = step_reg + STEP_W'(1);
                unique case (step_reg)
                    STEP_W'(1): begin
                        dx1_next = (COORD_W+1)'(v1x) - (COORD_W+1)'(v0x);
                        dy1_next = (COORD_W+1)'(v1y) - (COORD_W+1)'(v0y);
                        dz1_next = (VZ_W+1)'(v1z) - (VZ_W+1)'(v0z);
                    end
                    STEP_W'(2): begin
                        dx2_next = (COORD_W+1)'(v1x) - (COORD_W+1)'(v0x);
                        dy2_next = (COORD_W+1)'(v1y) - (COORD_W+1)'(v0y);
                        dz2_next = (VZ_W+1)'(v1z) - (VZ_W+1)'(v0z);
                    end
                    STEP_W'(3): begin
                        mul_a = MULA_W'(dy1_reg);
                        mul_b = MULB_W'(dz2_reg);
                    end
                    STEP_W'(4): begin
                        acc_next = ACC_W'(prod_reg);
                        mul_a    = MULA_W'(dz1_reg);
                        mul_b    = MULB_W'(dy2_reg);
                    end
                    STEP_W'(5): begin
                        pa_next = PLANE_W'(acc_reg - ACC_W'(prod_reg));
                        mul_a   = MULA_W'(dz1_reg);
                        mul_b   = MULB_W'(dx2_reg);
                    end
                    STEP_W'(6): begin
                        acc_next = ACC_W'(prod_reg);
                        mul_a    = MULA_W'(dx1_reg);
                        mul_b    = MULB_W'(dz2_reg);
                    end
                    STEP_W'(7): begin
                        pb_next = PLANE_W'(acc_reg - ACC_W'(prod_reg));
                        mul_a   = MULA_W'(dx1_reg);
                        mul_b   = MULB_W'(dy2_reg);
                    end
                    STEP_W'(8): begin
                        acc_next = ACC_W'(prod_reg);
                        mul_a    = MULA_W'(dy1_reg);
                        mul_b    = MULB_W'(dx2_reg);
                    end
                    STEP_W'(9): begin
                        pc_next = PLANE_W'(acc_reg - ACC_W'(prod_reg));
                        mul_a   = MULA_W'(pa_reg);
                        mul_b   = MULB_W'(v0x);
                    end
                    STEP_W'(10): begin
                        acc_next = ACC_W'(prod_reg);
                        mul_a    = MULA_W'(pb_reg);
                        mul_b    = MULB_W'(v0y);
                    end
                    STEP_W'(11): begin
                        acc_next = acc_reg + ACC_W'(prod_reg);
                        mul_a    = MULA_W'(pc_reg);
                        mul_b    = MULB_W'(v0z);
                    end
                    STEP_W'(12): begin
                        pd_next    = PD_W'(-(acc_reg + ACC_W'(prod_reg)));
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            ST_FETCH: begin
                // The pixel store read of this item is issued here; its data is registered for the update.
                step_next = '0;
                if (item_reg.kind == KIND_TEST && complete_reg && vcount_reg != '0) begin
                    state_next = ST_EDGE;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_EDGE: begin
                step_next = step_reg + STEP_W'(1);
                unique case (step_reg)
                    STEP_W'(1): begin
                        cross_next = (v0y > item_reg.y) != (v1y > item_reg.y);
                        dypos_next = (dyv > 0);
                        mul_a      = MULA_W'(xdiff);
                        mul_b      = MULB_W'(dyv);
                    end
                    STEP_W'(2): begin
                        lhs_next = prod_reg;
                        mul_a    = MULA_W'(bxa);
                        mul_b    = MULB_W'(yay);
                    end
                    STEP_W'(3): begin
                        if (cross_reg && (dypos_reg ? (lhs_reg < prod_reg)
                                                    : (lhs_reg > prod_reg))) begin
                            hits_next = !hits_reg;
                        end
                        step_next = '0;
                        if (edge_inc == vcount_reg) begin
                            // All edges walked: depth only for a visible, valid hit.
                            if (hits_next && !degen && item_reg.on_screen) begin
                                state_next = ST_DEPTH;
                            end else begin
                                state_next = ST_UPDATE;
                            end
                        end else begin
                            edge_next = edge_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DEPTH: begin
                step_next = step_reg + STEP_W'(1);
                unique case (step_reg)
                    STEP_W'(0): begin
                        mul_a = MULA_W'(pa_reg);
                        mul_b = MULB_W'(item_reg.x);
                    end
                    STEP_W'(1): begin
                        acc_next = ACC_W'(prod_reg);
                        mul_a    = MULA_W'(pb_reg);
                        mul_b    = MULB_W'(item_reg.y);
                    end
                    default: begin
                        // Numerator is -(Ax+By+D)*256; divide magnitudes.
                        dvd_next   = {sum_mag[SUM_W-1:0], 8'b0};
                        dvs_next   = pc_reg[PLANE_W-1] ? PLANE_W'(-pc_reg)
                                                       : PLANE_W'(pc_reg);
                        rem_next   = '0;
                        qneg_next  = (sum_w > 0) ^ pc_reg[PLANE_W-1];
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                endcase
            end
            ST_DIV: begin
                step_next = step_reg + STEP_W'(1);
                if (!trial[PLANE_W]) begin
                    rem_next = trial[PLANE_W-1:0];
                end else begin
                    rem_next = {rem_reg[PLANE_W-2:0], dvd_reg[NUM_W-1]};
                end
                dvd_next = {dvd_reg[NUM_W-2:0], !trial[PLANE_W]};
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    depth_ok_next = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                res_inside_next  = inside_w;
                res_written_next = 1'b0;
                res_depth_next   = '0;
                res_color_next   = '0;
                if (item_reg.on_screen) begin
                    res_depth_next = pix_rd_reg[DEPTH_W+COLOR_W-1 -: DEPTH_W];
                    res_color_next = pix_rd_reg[COLOR_W-1:0];
                    if (item_reg.kind == KIND_CLEAR) begin
                        pix_we           = 1'b1;
                        res_written_next = 1'b1;
                        res_depth_next   = clear_depth;
                        res_color_next   = clear_color;
                    end else if (item_reg.kind == KIND_TEST && depth_ok_reg &&
                                 zsat > stored_depth) begin
                        pix_we           = 1'b1;
                        pix_wd           = {zsat, pcolor_reg};
                        res_written_next = 1'b1;
                        res_depth_next   = zsat;
                        res_color_next   = pcolor_reg;
                    end
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (vtx_we) begin
            vtx_mem[vtx_wa] <= vtx_wd;
        end
        rd0_reg <= vtx_mem[ra0];
        rd1_reg <= vtx_mem[ra1];
    end

    always_ff @(posedge aclk) begin
        if (pix_we) begin
            pix_mem[item_reg.pix] <= pix_wd;
        end
        pix_rd_reg <= pix_mem[item_reg.pix];
    end

    always_ff @(posedge aclk) begin
        prod_reg        <= mul_a * mul_b;
        item_reg        <= item_next;
        step_reg        <= step_next;
        pa_reg          <= pa_next;
        pb_reg          <= pb_next;
        pc_reg          <= pc_next;
        pd_reg          <= pd_next;
        pcolor_reg      <= pcolor_next;
        dx1_reg         <= dx1_next;
        dy1_reg         <= dy1_next;
        dz1_reg         <= dz1_next;
        dx2_reg         <= dx2_next;
        dy2_reg         <= dy2_next;
        dz2_reg         <= dz2_next;
        acc_reg         <= acc_next;
        lhs_reg         <= lhs_next;
        edge_reg        <= edge_next;
        hits_reg        <= hits_next;
        cross_reg       <= cross_next;
        dypos_reg       <= dypos_next;
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        dvs_reg         <= dvs_next;
        qneg_reg        <= qneg_next;
        depth_ok_reg    <= depth_ok_next;
        res_inside_reg  <= res_inside_next;
        res_written_reg <= res_written_next;
        res_depth_reg   <= res_depth_next;
        res_color_reg   <= res_color_next;
        if (done_reg && out_free) begin
            m_inside_reg  <= res_inside_reg;
            m_written_reg <= res_written_reg;
            m_degen_reg   <= degen;
            m_depth_reg   <= res_depth_reg;
            m_color_reg   <= res_color_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            vcount_reg   <= '0;
            complete_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            vcount_reg   <= vcount_next;
            complete_reg <= complete_next;
            if (done_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_inside_res  = m_inside_reg;
    assign m_written     = m_written_reg;
    assign m_degenerate  = m_degen_reg;
    assign m_pixel_depth = $signed(m_depth_reg);
    assign m_pixel_red   = m_color_reg[23:16];
    assign m_pixel_green = m_color_reg[15:8];
    assign m_pixel_blue  = m_color_reg[7:0];

endmodule

`default_nettype wire

// ===== src/zbuffer_polygon_fill.sv =====
// A vertex load stores the vertex; a closing vertex of a polygon of three or
// more also sets up the plane. Clear and read go via fetch to update; pixel
// tests walk each edge and, for a depth, the one-bit-per-cycle restoring divider.
// One item is in the sequencer at a time; a two-beat queue takes input until full.
// Reset clears control and the polygon state; the pixel stores are undefined
// until each pixel is cleared, and no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// zbuffer_polygon_fill
// Top level: configuration registers, input queue and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module zbuffer_polygon_fill
    import zbpf_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_kind,
    input  wire logic signed [COORD_W-1:0] s_coord_x,
    input  wire logic signed [COORD_W-1:0] s_coord_y,
    input  wire logic signed [VZ_W-1:0]    s_vertex_depth,
    input  wire logic                      s_last_vertex,
    input  wire logic [7:0]                s_color_red,
    input  wire logic [7:0]                s_color_green,
    input  wire logic [7:0]                s_color_blue,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_inside_res,
    output logic                           m_written,
    output logic                           m_degenerate,
    output logic signed [DEPTH_W-1:0]      m_pixel_depth,
    output logic [7:0]                     m_pixel_red,
    output logic [7:0]                     m_pixel_green,
    output logic [7:0]                     m_pixel_blue
);

    logic signed [DEPTH_W-1:0] clear_depth_reg;
    logic [COLOR_W-1:0]        clear_color_reg;
    logic                      cfg_wr, q_valid, q_ready;
    item_t                     q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                CFG_CLEAR_DEPTH: prdata = 32'(clear_depth_reg);
                CFG_CLEAR_COLOR: prdata = 32'(clear_color_reg);
                default:         prdata = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_depth_reg <= -24'sd256;
            clear_color_reg <= 24'hFF_FFFF;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_CLEAR_DEPTH) begin
                clear_depth_reg <= $signed(pwdata[DEPTH_W-1:0]);
            end else begin
                clear_color_reg <= pwdata[COLOR_W-1:0];
            end
        end
    end

    zbpf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .s_vertex_depth (s_vertex_depth),
        .s_last_vertex  (s_last_vertex),
        .s_color_red    (s_color_red),
        .s_color_green  (s_color_green),
        .s_color_blue   (s_color_blue),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item)
    );

    zbpf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clear_depth   (clear_depth_reg),
        .clear_color   (clear_color_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .m_written     (m_written),
        .m_degenerate  (m_degenerate),
        .m_pixel_depth (m_pixel_depth),
        .m_pixel_red   (m_pixel_red),
        .m_pixel_green (m_pixel_green),
        .m_pixel_blue  (m_pixel_blue)
    );

endmodule

`default_nettype wire

// ===== src/zbpf_checker.sv =====
// ----------------------------------------------------------------------------
// zbpf_checker
// Port-level checks of the z-buffer polygon fill block.
// ----------------------------------------------------------------------------
`default_nettype none

module zbpf_checker
    import zbpf_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_inside_res,
    input wire logic                      m_written,
    input wire logic                      m_degenerate,
    input wire logic signed [DEPTH_W-1:0] m_pixel_depth
);

    logic [2:0] pend_reg;

    // Beats accepted on the input side whose result has not left yet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_depth))
        else $error("result beat changed while stalled");

    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 3'd0)
        else $error("result beat without an accepted input beat");

    a_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_written && m_inside_res |-> !m_degenerate)
        else $error("pixel written for a degenerate polygon");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind zbuffer_polygon_fill zbpf_checker u_zbpf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_inside_res  (m_inside_res),
    .m_written     (m_written),
    .m_degenerate  (m_degenerate),
    .m_pixel_depth (m_pixel_depth)
);

`default_nettype wire
